// ----- rtl/bmmu_pkg.sv -----
package bmmu_pkg;

    localparam int unsigned REG_COUNT = 64;
    localparam int unsigned REG_IDX_W = 6;

    localparam logic [1:0] CMD_MEM_XLATE = 2'd0;
    localparam logic [1:0] CMD_IO_READ   = 2'd1;
    localparam logic [1:0] CMD_IO_WRITE  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_CNTLA0 = 6'h00;
    localparam logic [REG_IDX_W-1:0] REG_CNTLB0 = 6'h02;
    localparam logic [REG_IDX_W-1:0] REG_CNTLB1 = 6'h03;
    localparam logic [REG_IDX_W-1:0] REG_STAT0  = 6'h04;
    localparam logic [REG_IDX_W-1:0] REG_CNTR   = 6'h0A;
    localparam logic [REG_IDX_W-1:0] REG_CMR    = 6'h1E;
    localparam logic [REG_IDX_W-1:0] REG_DSTAT  = 6'h30;
    localparam logic [REG_IDX_W-1:0] REG_ITC    = 6'h34;
    localparam logic [REG_IDX_W-1:0] REG_RCR    = 6'h36;
    localparam logic [REG_IDX_W-1:0] REG_CBR    = 6'h38;
    localparam logic [REG_IDX_W-1:0] REG_BBR    = 6'h39;
    localparam logic [REG_IDX_W-1:0] REG_CBAR   = 6'h3A;
    localparam logic [REG_IDX_W-1:0] REG_ICR    = 6'h3F;

    localparam logic [7:0] CBAR_RESET = 8'hF0;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] logical_address;
        logic [7:0]  write_byte;
    } in_item_t;

    typedef struct packed {
        logic [19:0] physical_address;
        logic [7:0]  read_byte;
        logic        internal_hit;
    } out_item_t;

    // Power-on contents of the register file; unlisted registers are zero.
    function automatic logic [7:0] reg_reset_value(input logic [REG_IDX_W-1:0] idx);
        logic [7:0] val;
        case (idx)
            REG_CNTLA0: val = 8'h10;
            REG_CNTLB0: val = 8'h07;
            REG_CNTLB1: val = 8'h07;
            REG_STAT0:  val = 8'h04;
            REG_CNTR:   val = 8'h07;
            REG_CMR:    val = 8'h7F;
            REG_DSTAT:  val = 8'h30;
            REG_ITC:    val = 8'h01;
            REG_RCR:    val = 8'hC0;
            REG_CBAR:   val = CBAR_RESET;
            default:    val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/bmmu_ram.sv -----
module bmmu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/banked_mmu_io_register_window.sv -----
// The result is registered and strobed in the cycle after the request is accepted.
// Throughput: one item per cycle; busy is never raised, since the register file
// RAM takes a read or a write in the accepting cycle and returns registered data.
// Reset: rst_n clears all valid bits and loads the bank registers with their
// power-on values; entries never written since reset read as their reset values.
// The result is shown for one cycle and cannot be stalled by the receiver.
module banked_mmu_io_register_window
    import bmmu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  request,
    output logic      result_valid,
    output out_item_t result
);

    logic [REG_COUNT-1:0] valid_reg;
    logic [REG_COUNT-1:0] valid_next;
    logic [7:0]           cbr_reg;
    logic [7:0]           bbr_reg;
    logic [7:0]           cbar_reg;
    logic [7:0]           icr_reg;
    logic                 done_reg;

    logic [19:0]          pa_reg;
    logic                 hit_reg;
    logic                 rd_hit_reg;
    logic                 entry_valid_reg;
    logic [REG_IDX_W-1:0] idx_reg;

    logic                 accept;
    logic                 is_io;
    logic                 win_hit;
    logic                 wr_hit;
    logic                 rd_hit;
    logic [REG_IDX_W-1:0] idx;
    logic [3:0]           page;
    logic [19:0]          la_ext;
    logic [19:0]          xlate_pa;
    logic [19:0]          pa_next;
    logic [7:0]           ram_rdata;
    logic [7:0]           stored_byte;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign idx    = request.logical_address[REG_IDX_W-1:0];
    assign is_io  = (request.command == CMD_IO_READ) || (request.command == CMD_IO_WRITE);
    assign win_hit = (request.logical_address[15:6] == {8'h00, icr_reg[7:6]});
    assign wr_hit  = accept && (request.command == CMD_IO_WRITE) && win_hit;
    assign rd_hit  = (request.command == CMD_IO_READ) && win_hit;

    // Three areas: common 0 passes, the bank area adds BBR, common 1 adds CBR.
    assign page   = request.logical_address[15:12];
    assign la_ext = {4'h0, request.logical_address};

    always_comb
    begin
        if (page < cbar_reg[3:0])
        begin
            xlate_pa = la_ext;
        end
        else if (page < cbar_reg[7:4])
        begin
            xlate_pa = la_ext + {bbr_reg, 12'h000};
        end
        else
        begin
            xlate_pa = la_ext + {cbr_reg, 12'h000};
        end
        pa_next = is_io ? la_ext : xlate_pa;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_hit)
        begin
            valid_next[idx] = 1'b1;
        end
    end

    bmmu_ram #(
        .WIDTH(8),
        .DEPTH(REG_COUNT)
    ) u_regfile (
        .clk  (clk),
        .we   (wr_hit),
        .waddr(idx),
        .wdata(request.write_byte),
        .re   (accept),
        .raddr(idx),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            cbr_reg   <= 8'h00;
            bbr_reg   <= 8'h00;
            cbar_reg  <= CBAR_RESET;
            icr_reg   <= 8'h00;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= accept;
            // Shadow copies of the MMU registers feed translation and window decode.
            if (wr_hit)
            begin
                case (idx)
                    REG_CBR:  cbr_reg  <= request.write_byte;
                    REG_BBR:  bbr_reg  <= request.write_byte;
                    REG_CBAR: cbar_reg <= request.write_byte;
                    REG_ICR:  icr_reg  <= request.write_byte;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pa_reg          <= pa_next;
            hit_reg         <= is_io && win_hit;
            rd_hit_reg      <= rd_hit;
            entry_valid_reg <= valid_reg[idx];
            idx_reg         <= idx;
        end
    end

    assign stored_byte = entry_valid_reg ? ram_rdata : reg_reset_value(idx_reg);

    assign result_valid             = done_reg;
    assign result.physical_address  = pa_reg;
    assign result.read_byte         = rd_hit_reg ? stored_byte : 8'h00;
    assign result.internal_hit      = hit_reg;

endmodule

// ----- bench/mmu_window_checker.sv -----
`timescale 1ns / 1ps

module mmu_window_checker
    import bmmu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_item_t  request,
    input  logic      result_valid,
    input  out_item_t result,
    output int        fail_count,
    output int        pending
);

    logic [7:0] io_regs [REG_COUNT];
    out_item_t  expected_results [$];
    int         mismatches;

    // Translates or performs the I/O access, updating the shadow register file.
    function automatic out_item_t access_window(input in_item_t it);
        out_item_t     res;
        logic [3:0]    page;
        logic [7:0]    cbar;
        logic [19:0]   la_ext;
        logic          is_io;
        begin
            res     = '0;
            page    = it.logical_address[15:12];
            cbar    = io_regs[REG_CBAR];
            la_ext  = {4'h0, it.logical_address};
            is_io   = (it.command == CMD_IO_READ) || (it.command == CMD_IO_WRITE);
            if (is_io) begin
                res.physical_address = la_ext;
                if (it.logical_address[15:8] == 8'h00
                    && it.logical_address[7:6] == io_regs[REG_ICR][7:6]) begin
                    res.internal_hit = 1'b1;
                    if (it.command == CMD_IO_READ)
                        res.read_byte = io_regs[it.logical_address[5:0]];
                    else
                        io_regs[it.logical_address[5:0]] = it.write_byte;
                end
            end
            else if (page < cbar[3:0])
                res.physical_address = la_ext;
            else if (page < cbar[7:4])
                res.physical_address = la_ext + {io_regs[REG_BBR], 12'h000};
            else
                res.physical_address = la_ext + {io_regs[REG_CBR], 12'h000};
            return res;
        end
    endfunction

    function automatic logic [7:0] power_on_value(input int idx);
        begin
            case (idx)
                REG_CNTLA0: return 8'h10;
                REG_CNTLB0: return 8'h07;
                REG_CNTLB1: return 8'h07;
                REG_STAT0:  return 8'h04;
                REG_CNTR:   return 8'h07;
                REG_CMR:    return 8'h7F;
                REG_DSTAT:  return 8'h30;
                REG_ITC:    return 8'h01;
                REG_RCR:    return 8'hC0;
                REG_CBAR:   return 8'hF0;
                default:    return 8'h00;
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            for (int i = 0; i < REG_COUNT; i++)
                io_regs[i] = power_on_value(i);
            expected_results.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            // Results are checked before the new item is predicted, so an item
            // accepted on this edge never answers for the previous one.
            if (result_valid) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result pa=%h rd=%h hit=%b", $realtime,
                                 result.physical_address, result.read_byte,
                                 result.internal_hit);
                end
                else begin
                    want = expected_results.pop_front();
                    if (result.physical_address !== want.physical_address
                        || result.read_byte !== want.read_byte
                        || result.internal_hit !== want.internal_hit) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch pa exp %h got %h, rd exp %h got %h, hit exp %b got %b",
                                     $realtime, want.physical_address,
                                     result.physical_address, want.read_byte,
                                     result.read_byte, want.internal_hit,
                                     result.internal_hit);
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(access_window(request));
            fail_count <= mismatches;
            pending    <= expected_results.size();
        end
    end

endmodule

// ----- bench/banked_mmu_io_register_window_tb.sv -----
`timescale 1ns / 1ps

module banked_mmu_io_register_window_tb;
    import bmmu_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  request;
    logic      result_valid;
    out_item_t result;
    int        fail_count;
    int        pending;

    int         idle_pct;
    logic [7:0] window_icr;

    banked_mmu_io_register_window u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    mmu_window_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Presents one item and returns right after the edge that accepts it.
    task automatic issue(input logic [1:0] cmd, input logic [15:0] addr,
                         input logic [7:0] data);
        in_item_t it;
        begin
            it.command         = cmd;
            it.logical_address = addr;
            it.write_byte      = data;
            if (idle_pct > 0 && $urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge clk);
            end
            start   <= 1'b1;
            request <= it;
            @(negedge clk);
            while (busy) @(negedge clk);
            @(posedge clk);
            // Keep track of where the register window sits.
            if (cmd == CMD_IO_WRITE && addr[15:8] == 8'h00
                && addr[7:6] == window_icr[7:6] && addr[5:0] == REG_ICR)
                window_icr = data;
        end
    endtask

    task automatic drain;
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
        end
    endtask

    task automatic random_item;
        int          pick;
        logic [5:0]  idx;
        logic [15:0] port;
        begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 35)
            begin
                case ($urandom_range(3))
                    0: idx = REG_CBR;
                    1: idx = REG_BBR;
                    2: idx = REG_CBAR;
                    default: idx = REG_ICR;
                endcase
            end
            else
                idx = 6'($urandom_range(63));
            port = {8'h00, window_icr[7:6], idx};
            if (pick < 38)
                issue(CMD_MEM_XLATE, 16'($urandom_range(16'hFFFF)),
                      8'($urandom_range(255)));
            else if (pick < 42)
                issue(CMD_SPARE, 16'($urandom_range(16'hFFFF)),
                      8'($urandom_range(255)));
            else if (pick < 64)
                issue(CMD_IO_READ, port, 8'($urandom_range(255)));
            else if (pick < 88)
                issue(CMD_IO_WRITE, port, 8'($urandom_range(255)));
            else
                issue(2'($urandom_range(2, 1)), 16'($urandom_range(16'hFFFF)),
                      8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int phase_idle [4];
        phase_idle = '{0, 79, 0, 34};
        rst_n      <= 1'b0;
        start      <= 1'b0;
        request    <= '0;
        idle_pct   = 0;
        window_icr = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Power-on state: CBAR splits at page 15, both bases zero.
        issue(CMD_MEM_XLATE, 16'h0000, 8'h00);
        issue(CMD_MEM_XLATE, 16'hFFFF, 8'hFF);
        issue(CMD_IO_READ, 16'h0000, 8'h00);
        issue(CMD_IO_READ, 16'h001E, 8'h00);
        issue(CMD_IO_READ, 16'h003A, 8'h00);
        issue(CMD_IO_READ, 16'h003F, 8'h00);
        issue(CMD_IO_READ, 16'h0040, 8'h00);
        issue(CMD_IO_WRITE, 16'hFFFF, 8'h5A);
        // Three areas: pages below 4, 4 to 7, and 8 upward.
        issue(CMD_IO_WRITE, 16'h0038, 8'hFF);
        issue(CMD_IO_WRITE, 16'h0039, 8'h80);
        issue(CMD_IO_WRITE, 16'h003A, 8'h84);
        issue(CMD_MEM_XLATE, 16'h3FFF, 8'h00);
        issue(CMD_MEM_XLATE, 16'h4000, 8'h00);
        issue(CMD_MEM_XLATE, 16'h8000, 8'h00);
        issue(CMD_MEM_XLATE, 16'hFFFF, 8'h00);
        issue(CMD_SPARE, 16'h6123, 8'h00);
        // Upper bound below the lower one leaves no bank area.
        issue(CMD_IO_WRITE, 16'h003A, 8'h48);
        issue(CMD_MEM_XLATE, 16'h5000, 8'h00);
        issue(CMD_MEM_XLATE, 16'h7FFF, 8'h00);
        // Moving the window takes effect on the very next item.
        issue(CMD_IO_WRITE, 16'h003F, 8'hC0);
        issue(CMD_IO_READ, 16'h003F, 8'h00);
        issue(CMD_IO_READ, 16'h00FF, 8'h00);
        issue(CMD_IO_WRITE, 16'h00D0, 8'hFF);
        issue(CMD_IO_READ, 16'h00D0, 8'h00);
        issue(CMD_IO_WRITE, 16'h00FF, 8'h00);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            repeat (340) random_item();
            drain();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
